// ----- sv/sliding_window_minimum_top_assert.svh -----
// Assertion macros for the sliding window minimum block.
`ifndef SLIDING_WINDOW_MINIMUM_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MINIMUM_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is low
`define SWM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also during reset
`define SWM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SWM_ASSERT(label, clk, rst_n, prop, msg)
`define SWM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- sv/swm_pkg.sv -----
// Shared types, constants and helpers of the sliding window minimum block.
`timescale 1ns / 1ps

package swm_pkg;

	localparam int SAMPLE_WIDTH   = 32;
	localparam int MAX_WINDOW_DEF = 64;
	localparam int CFG_WIDTH      = 7;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           first_in_sequence;
		logic                           last_in_sequence;
	} swm_in_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] window_min;
		logic                           last_of_sequence;
	} swm_out_t;

	function automatic logic signed [SAMPLE_WIDTH-1:0] smin(
		input logic signed [SAMPLE_WIDTH-1:0] a,
		input logic signed [SAMPLE_WIDTH-1:0] b
	);
		return (a < b) ? a : b;
	endfunction

endpackage

// ----- sv/sliding_window_minimum_top.sv -----
// Sliding window minimum filter: chain of min cells with a two-entry output buffer.
//
//  channel | direction | handshake           | payload
//  in      | into      | in_valid / in_stall | in_data   (swm_in_t)
//  out     | out of    | out_valid/out_stall | out_data  (swm_out_t)
//  cfg     | into      | cfg_valid/cfg_ready | cfg_data  (window_size)
//
// One sample per clock unless stalled; each cell updates once per accepted sample,
// so a result reaches out_valid the cycle after its sample is taken, unless an earlier
// result is still held there by out_stall, in which case it waits in the skid slot.
// Reset clears the sample count, the buffer flags and sets window_size to 1.
// in_stall rises only while the skid slot holds a result (out_stall held).
// Cell contents need no clearing: a cell is read only once it spans samples
// of the current sequence.
`timescale 1ns / 1ps

`include "sliding_window_minimum_top_assert.svh"

module sliding_window_minimum_top
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  swm_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output swm_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int EW    = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;
	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [CFG_WIDTH-1:0]           win_q;
	logic [CNT_W-1:0]               seen_q;
	logic                           acc;
	logic [EW-1:0]                  cfg_ext;
	logic [EW-1:0]                  eff;
	logic [EW-1:0]                  eff_m2;
	logic [CNT_W-1:0]               base;
	logic [CNT_W-1:0]               seen_new;
	logic                           produce;
	logic [IDX_W-1:0]               sel;
	logic signed [SAMPLE_WIDTH-1:0] cell_min [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] tap;
	swm_out_t                       res;
	logic                           buf_full;

	assign acc       = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;

	// zero acts as one, oversize saturates
	assign cfg_ext = EW'(win_q);
	assign eff     = (cfg_ext == '0) ? EW'(1) :
	                 (cfg_ext > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : cfg_ext;
	assign eff_m2  = eff - EW'(2);
	assign sel     = (eff >= EW'(2)) ? eff_m2[IDX_W-1:0] : '0;

	assign base     = in_data.first_in_sequence ? '0 : seen_q;
	assign seen_new = (base < CNT_W'(MAX_WINDOW)) ? base + CNT_W'(1) : base;
	assign produce  = EW'(seen_new) >= eff;

	genvar k;
	generate
		for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
			if (k == 0) begin : g_head
				swm_cell u_cell (
					.clk    (clk),
					.en     (acc),
					.sample (in_data.sample),
					.prev   (in_data.sample),
					.min_q  (cell_min[k])
				);
			end else begin : g_body
				swm_cell u_cell (
					.clk    (clk),
					.en     (acc),
					.sample (in_data.sample),
					.prev   (cell_min[k-1]),
					.min_q  (cell_min[k])
				);
			end
		end
	endgenerate

	// window w: new sample against the cell spanning the previous w-1 samples
	assign tap                  = cell_min[sel];
	assign res.window_min       = (eff == EW'(1)) ? in_data.sample : smin(in_data.sample, tap);
	assign res.last_of_sequence = in_data.last_in_sequence;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= CFG_WIDTH'(1);
			seen_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_q <= cfg_data;
			end
			if (acc) begin
				seen_q <= in_data.last_in_sequence ? '0 : seen_new;
			end
		end
	end

	swm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc & produce),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`SWM_ASSERT(a_last_clears, clk, arst_n, acc && in_data.last_in_sequence |=> seen_q == '0, "count not cleared after last")
	`SWM_ASSERT(a_count_bound, clk, arst_n, seen_q <= CNT_W'(MAX_WINDOW), "count above window depth")
	`SWM_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

// ----- sv/swm_cell.sv -----
// One cell of the min chain: holds the minimum over its span of recent samples.
`timescale 1ns / 1ps

module swm_cell
	import swm_pkg::*;
(
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] prev,
	output logic signed [SAMPLE_WIDTH-1:0] min_q
);

	// span grows by one over the neighbor's span
	always_ff @(posedge clk) begin
		if (en) begin
			min_q <= smin(sample, prev);
		end
	end

endmodule

// ----- sv/swm_out_buf.sv -----
// Two-entry output buffer: result register plus skid slot.
`timescale 1ns / 1ps

`include "sliding_window_minimum_top_assert.svh"

module swm_out_buf
	import swm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  swm_out_t push_data,
	output logic     full,
	output logic     out_valid,
	input  logic     out_stall,
	output swm_out_t out_data
);

	logic     out_valid_q;
	logic     skid_valid_q;
	swm_out_t out_q;
	swm_out_t skid_q;
	logic     pop;
	logic     load_out;
	logic     load_skid;

	assign pop       = out_valid_q & ~out_stall;
	assign load_out  = push & ~skid_valid_q & (~out_valid_q | pop);
	assign load_skid = push & ~skid_valid_q & out_valid_q & ~pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && pop) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= push_data;
		end
		if (load_skid) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SWM_ASSERT(a_skid_needs_out, clk, arst_n, skid_valid_q |-> out_valid_q, "skid full with output empty")
	`SWM_ASSERT(a_no_push_full, clk, arst_n, push |-> !skid_valid_q, "request pushed into full buffer")
	`SWM_ASSERT(a_skid_drains, clk, arst_n, skid_valid_q && pop |=> out_valid_q && !skid_valid_q, "skid did not drain")
	`SWM_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid_q || arst_n, "buffer not empty after reset")

endmodule

// ----- test/sliding_window_minimum_checker.sv -----
// Checker for the sliding window minimum block: watches the channels, predicts and compares.
`timescale 1ns / 1ps

module sliding_window_minimum_checker
	import swm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  swm_in_t              in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  swm_out_t             out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_WIDTH-1:0] cfg_data,
	output int                   mismatches,
	output int                   pending
);

	logic signed [SAMPLE_WIDTH-1:0] history [MAX_WINDOW_DEF];
	logic [CFG_WIDTH-1:0]           window_reg;
	int                             seq_count;
	swm_out_t                       min_queue [$];

	// zero acts as one, anything past the store depth is clipped
	function automatic int span_of(input logic [CFG_WIDTH-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_WINDOW_DEF)
			return MAX_WINDOW_DEF;
		return int'(w);
	endfunction

	task automatic take_sample(input swm_in_t req);
		int                             span;
		logic signed [SAMPLE_WIDTH-1:0] lowest;
		swm_out_t                       res;
		span = span_of(window_reg);
		if (req.first_in_sequence)
			seq_count = 0;
		for (int i = MAX_WINDOW_DEF - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = req.sample;
		if (seq_count < MAX_WINDOW_DEF)
			seq_count++;
		if (seq_count >= span) begin
			lowest = history[0];
			for (int i = 1; i < span; i++)
				if (history[i] < lowest)
					lowest = history[i];
			res.window_min       = lowest;
			res.last_of_sequence = req.last_in_sequence;
			min_queue.push_back(res);
		end
		// the count restarts after every last sample, flagged first or not
		if (req.last_in_sequence)
			seq_count = 0;
	endtask

	task automatic check_result(input swm_out_t got);
		swm_out_t want;
		if (min_queue.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result with nothing expected: min %0d last %0b",
					$realtime, got.window_min, got.last_of_sequence);
			mismatches++;
		end else begin
			want = min_queue.pop_front();
			if (got.window_min !== want.window_min ||
					got.last_of_sequence !== want.last_of_sequence) begin
				if (mismatches < 10)
					$display("%0t: mismatch: expected min %0d last %0b, got min %0d last %0b",
						$realtime, want.window_min, want.last_of_sequence,
						got.window_min, got.last_of_sequence);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_count  = 0;
			window_reg = 1;
			min_queue.delete();
			mismatches = 0;
			for (int i = 0; i < MAX_WINDOW_DEF; i++)
				history[i] = '0;
		end else begin
			// results are registered before they leave, so drain first
			if (out_valid && !out_stall)
				check_result(out_data);
			if (cfg_valid && cfg_ready)
				window_reg = cfg_data;
			if (in_valid && !in_stall)
				take_sample(in_data);
		end
		pending = min_queue.size();
	end

endmodule

// ----- test/tb_sliding_window_minimum_top.sv -----
// Testbench top for the sliding window minimum block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_sliding_window_minimum_top;
	import swm_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_PHASES  = 9;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	swm_in_t              in_data;
	logic                 out_valid;
	logic                 out_stall;
	swm_out_t             out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_WIDTH-1:0] cfg_data;

	int                   mismatches;
	int                   pending;
	int                   quiet_cycles;
	bit                   idle_on;
	logic [CFG_WIDTH-1:0] phase_win [NUM_PHASES];
	int                   phase_len [NUM_PHASES];
	int                   span;

	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

	sliding_window_minimum_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sliding_window_minimum_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 32);
	end

	// ends the run if no request moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic swm_in_t mk(input logic signed [SAMPLE_WIDTH-1:0] s,
			input logic first, input logic last);
		swm_in_t req;
		req.sample            = s;
		req.first_in_sequence = first;
		req.last_in_sequence  = last;
		return req;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2, 3: return SAMPLE_WIDTH'(int'($urandom_range(40)) - 20);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic send_item(input swm_in_t req);
		if (idle_on)
			while ($urandom_range(99) < 32) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// sender holds off until every expected result is out, plus a margin
	// for a sample that produced nothing and may still be in flight
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_WIDTH-1:0] w);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_items(input int count, input int eff);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 80) begin
				// well-formed sequence, mostly long enough to fill the window
				if ($urandom_range(9) == 0)
					len = int'($urandom_range(eff, 1));
				else
					len = eff + int'($urandom_range(12));
				for (int j = 0; j < len; j++)
					send_item(mk(rand_sample(), (j == 0) && ($urandom_range(99) < 85),
						j == len - 1));
				sent += len;
			end else begin
				send_item(mk(rand_sample(), 1'($urandom_range(1)), 1'($urandom_range(1))));
				sent++;
			end
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		idle_on   = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window of one after reset: pass-through, both flags on one sample
		send_item(mk(S_MAX, 1'b1, 1'b1));
		send_item(mk(S_MIN, 1'b1, 1'b0));
		send_item(mk(0, 1'b0, 1'b0));
		send_item(mk(-1, 1'b0, 1'b0));
		send_item(mk(1, 1'b0, 1'b1));

		write_window(7'd3);
		// too short for the window
		send_item(mk(5, 1'b1, 1'b0));
		send_item(mk(-7, 1'b0, 1'b1));
		// new sequence started by the previous last flag alone
		send_item(mk(S_MIN, 1'b0, 1'b0));
		send_item(mk(S_MAX, 1'b0, 1'b0));
		send_item(mk(S_MAX, 1'b0, 1'b0));
		send_item(mk(0, 1'b0, 1'b1));
		// window shrinks in the middle of a sequence
		send_item(mk(100, 1'b1, 1'b0));
		send_item(mk(-100, 1'b0, 1'b0));
		write_window(7'd2);
		send_item(mk(50, 1'b0, 1'b0));
		send_item(mk(60, 1'b0, 1'b1));

		write_window(7'd0);
		send_item(mk(42, 1'b1, 1'b1));
		send_item(mk(S_MIN, 1'b1, 1'b0));
		send_item(mk(S_MAX, 1'b0, 1'b1));

		phase_win = '{7'd1, 7'd3, 7'd0, 7'd64, 7'd2, 7'd127, 7'd5, 7'd1, 7'd1};
		phase_win[7] = CFG_WIDTH'($urandom_range(12, 1));
		phase_len = '{45, 45, 45, 64, 100, 64, 45, 45, 45};
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_window(phase_win[p]);
			idle_on = (p != 4);
			if (phase_win[p] == 0)
				span = 1;
			else if (phase_win[p] > MAX_WINDOW_DEF)
				span = MAX_WINDOW_DEF;
			else
				span = int'(phase_win[p]);
			run_items(phase_len[p], span);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
